// File: design/slab_volume_ray_intersect_top_defines.svh
// Assertion helpers for the slab volume control module.
// Each macro expands to one labeled concurrent assertion on clock, gated by reset.
`ifndef SLAB_VOLUME_RAY_INTERSECT_TOP_DEFINES_SVH
`define SLAB_VOLUME_RAY_INTERSECT_TOP_DEFINES_SVH

// same-cycle implication
`define SVRI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SVRI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/svri_pkg.sv
`default_nettype none

package svri_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_WIDEN = 2'd1;
   localparam logic [1:0] OP_RAY   = 2'd2;

   localparam logic [1:0] MODE_NEAR = 2'd1;
   localparam logic [1:0] MODE_EDGE = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // sqrt(3)/3 in Q16.16
   localparam logic signed [32:0] DIAG_K = 33'sd37837;
   localparam logic [30:0] EDGE_RESET = 31'd26214;
   localparam logic [2:0] AXES = 3'd3;

   typedef enum logic [1:0] {
      SRC_O = 2'd0,
      SRC_D = 2'd1,
      SRC_P = 2'd2
   } src_type;

   typedef struct packed {
      logic       cap;
      logic       clear;
      logic       widen;
      logic [2:0] idx;
      logic       dot_go;
      src_type    dot_src;
      logic       load_on;
      logic       load_dn;
      logic       div_start;
      logic       div_far;
      logic       div_step;
      logic       load_tn;
      logic       upd;
      logic       pmul_go;
      logic [1:0] pmul_comp;
      logic       p_load;
      logic [1:0] pload_comp;
      logic       sel_t;
      logic       cnt_clr;
      logic       chk;
      logic       res_basic;
      logic       res_edge;
      logic       res_miss;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic edge_mode;
      logic range_ok;
      logic edge_now;
   } status_type;

   // diagonal normals (+,+,+), (-,+,+), (-,-,+), (+,-,+), before scaling
   function automatic logic signed [34:0] diag_sum(input logic [2:0] i,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
      logic signed [34:0] sx;
      logic signed [34:0] sy;
      logic signed [34:0] sz;
      sx = 35'(x);
      sy = 35'(y);
      sz = 35'(z);
      case (i)
         3'd4: sx = -sx;
         3'd5: begin
            sx = -sx;
            sy = -sy;
         end
         3'd6: sy = -sy;
         default: ;
      endcase
      return sx + sy + sz;
   endfunction

   function automatic logic signed [31:0] axis_comp(input logic [2:0] i,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y,
                                                    input logic signed [31:0] z);
      case (i)
         3'd0: return x;
         3'd1: return y;
         default: return z;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: design/svri_datapath.sv
`default_nettype none

module svri_datapath #(
   parameter int SLABS = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire svri_pkg::cmd_type   cmd,
   output svri_pkg::status_type     st,
   input  wire logic [1:0]          req_mode,
   input  wire logic [2:0]          req_slab,
   input  wire logic signed [31:0]  req_near_value,
   input  wire logic signed [31:0]  req_far_value,
   input  wire logic signed [31:0]  req_origin_x,
   input  wire logic signed [31:0]  req_origin_y,
   input  wire logic signed [31:0]  req_origin_z,
   input  wire logic signed [31:0]  req_dir_x,
   input  wire logic signed [31:0]  req_dir_y,
   input  wire logic signed [31:0]  req_dir_z,
   input  wire logic                csr_valid,
   input  wire logic [30:0]         csr_edge_width,
   output logic                     rsp_hit,
   output logic signed [31:0]       rsp_distance
);

   localparam int IW = (SLABS > 1) ? $clog2(SLABS) : 1;

   logic signed [31:0] near_ff [SLABS];
   logic signed [31:0] far_ff  [SLABS];
   logic [30:0]        ew_ff;

   logic [1:0]         mode_ff;
   logic [2:0]         slab_ff;
   logic signed [31:0] nv_ff, fv_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;

   logic signed [67:0] prod_ff;
   logic signed [31:0] axis_ff;
   logic signed [34:0] on_ff, dn_ff;

   logic [35:0]        rem_ff;
   logic [31:0]        nlow_ff, q_ff;
   logic [34:0]        dvs_ff;
   logic               ovf_ff, neg_ff;

   logic signed [31:0] tn_ff, tmin_ff, tmax_ff;
   logic               seen_ff;
   logic               res_hit_ff;
   logic signed [31:0] res_dist_ff;
   logic               rsp_hit_ff;
   logic signed [31:0] rsp_dist_ff;

   logic [2:0]         bidx;
   logic signed [31:0] nb, fb;
   logic signed [31:0] vx, vy, vz;
   logic signed [34:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [67:0] prod_in;
   logic signed [67:0] rnd;
   logic signed [34:0] dot_val;
   logic signed [35:0] off;
   logic [35:0]        absoff;
   logic [34:0]        absd;
   logic [51:0]        numer;
   logic [35:0]        r2;
   logic               ge;
   logic signed [31:0] t_res, t_sel;
   logic signed [31:0] t_lo, t_hi;
   logic signed [31:0] oc, dc;
   logic signed [67:0] psum;
   logic signed [31:0] psat;
   logic signed [35:0] en, ef;
   logic [35:0]        an, af;
   logic               inc;
   logic               basic_hit;
   logic signed [31:0] basic_dist;

   // bound store: one address per cycle
   assign bidx = cmd.widen ? slab_ff : cmd.idx;
   assign nb   = near_ff[bidx[IW-1:0]];
   assign fb   = far_ff[bidx[IW-1:0]];

   always_comb begin
      case (cmd.dot_src)
         svri_pkg::SRC_O: begin
            vx = ox_ff; vy = oy_ff; vz = oz_ff;
         end
         svri_pkg::SRC_D: begin
            vx = dx_ff; vy = dy_ff; vz = dz_ff;
         end
         default: begin
            vx = px_ff; vy = py_ff; vz = pz_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.pmul_comp)
         2'd0:    dc = dx_ff;
         2'd1:    dc = dy_ff;
         default: dc = dz_ff;
      endcase
      case (cmd.pload_comp)
         2'd0:    oc = ox_ff;
         2'd1:    oc = oy_ff;
         default: oc = oz_ff;
      endcase
   end

   assign t_sel = cmd.sel_t ? tmax_ff : tmin_ff;

   // shared multiplier: scaled dot product or direction times t
   assign mul_a   = cmd.pmul_go ? 35'(dc) : svri_pkg::diag_sum(cmd.idx, vx, vy, vz);
   assign mul_b   = cmd.pmul_go ? 33'(t_sel) : svri_pkg::DIAG_K;
   assign prod_in = mul_a * mul_b;

   // round half up, then floor shift
   assign rnd     = prod_ff + 68'sd32768;
   assign dot_val = (cmd.idx >= svri_pkg::AXES) ? 35'(rnd >>> 16) : 35'(axis_ff);

   // divider setup
   assign off    = -36'(cmd.div_far ? fb : nb) - 36'(on_ff);
   assign absoff = off[35] ? 36'(-off) : 36'(off);
   assign absd   = dn_ff[34] ? 35'(-dn_ff) : 35'(dn_ff);
   assign numer  = {absoff, 16'h0000};
   assign r2     = {rem_ff[34:0], nlow_ff[31]};
   assign ge     = r2 >= {1'b0, dvs_ff};

   // overflow also covers the zero divisor: sign then picks the rail
   always_comb begin
      if (!neg_ff) begin
         t_res = (ovf_ff || q_ff[31]) ? svri_pkg::Q_MAX : $signed(q_ff);
      end else begin
         t_res = (ovf_ff || q_ff > 32'h8000_0000) ? svri_pkg::Q_MIN : $signed(32'd0 - q_ff);
      end
   end

   assign t_lo = (tn_ff < t_res) ? tn_ff : t_res;
   assign t_hi = (tn_ff < t_res) ? t_res : tn_ff;

   // point on the ray
   assign psum = 68'(oc) + (prod_ff >>> 16);
   always_comb begin
      if (psum > 68'(svri_pkg::Q_MAX)) begin
         psat = svri_pkg::Q_MAX;
      end else if (psum < 68'(svri_pkg::Q_MIN)) begin
         psat = svri_pkg::Q_MIN;
      end else begin
         psat = 32'(psum);
      end
   end

   // edge proximity
   assign en  = -36'(nb) - 36'(dot_val);
   assign ef  = -36'(fb) - 36'(dot_val);
   assign an  = en[35] ? 36'(-en) : 36'(en);
   assign af  = ef[35] ? 36'(-ef) : 36'(ef);
   assign inc = (an < 36'(ew_ff)) || (af < 36'(ew_ff));

   always_comb begin
      if (mode_ff == svri_pkg::MODE_NEAR) begin
         basic_hit  = (tmax_ff > 32'sd0) && (tmin_ff <= tmax_ff);
         basic_dist = tmin_ff;
      end else begin
         basic_hit  = (tmax_ff >= 32'sd0) && (tmin_ff <= tmax_ff);
         basic_dist = (tmin_ff < 32'sd0) ? tmax_ff : tmin_ff;
      end
   end

   assign st.edge_mode = (mode_ff == svri_pkg::MODE_EDGE);
   assign st.range_ok  = (tmax_ff >= 32'sd0) && (tmin_ff <= tmax_ff);
   assign st.edge_now  = inc && seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLABS; i++) begin
            near_ff[i] <= svri_pkg::Q_MAX;
            far_ff[i]  <= svri_pkg::Q_MIN;
         end
         ew_ff <= svri_pkg::EDGE_RESET;
      end else begin
         if (csr_valid) begin
            ew_ff <= csr_edge_width;
         end
         if (cmd.clear) begin
            for (int i = 0; i < SLABS; i++) begin
               near_ff[i] <= svri_pkg::Q_MAX;
               far_ff[i]  <= svri_pkg::Q_MIN;
            end
         end else if (cmd.widen && (32'(slab_ff) < SLABS)) begin
            if (nv_ff < nb) begin
               near_ff[slab_ff[IW-1:0]] <= nv_ff;
            end
            if (fv_ff > fb) begin
               far_ff[slab_ff[IW-1:0]] <= fv_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         mode_ff <= req_mode;
         slab_ff <= req_slab;
         nv_ff   <= req_near_value;
         fv_ff   <= req_far_value;
         ox_ff   <= req_origin_x;
         oy_ff   <= req_origin_y;
         oz_ff   <= req_origin_z;
         dx_ff   <= req_dir_x;
         dy_ff   <= req_dir_y;
         dz_ff   <= req_dir_z;
         tmin_ff <= svri_pkg::Q_MIN;
         tmax_ff <= svri_pkg::Q_MAX;
      end else if (cmd.upd) begin
         if (t_lo > tmin_ff) begin
            tmin_ff <= t_lo;
         end
         if (t_hi < tmax_ff) begin
            tmax_ff <= t_hi;
         end
      end
      if (cmd.dot_go || cmd.pmul_go) begin
         prod_ff <= prod_in;
      end
      if (cmd.dot_go) begin
         axis_ff <= svri_pkg::axis_comp(cmd.idx, vx, vy, vz);
      end
      if (cmd.load_on) begin
         on_ff <= dot_val;
      end
      if (cmd.load_dn) begin
         dn_ff <= dot_val;
      end
      if (cmd.div_start) begin
         rem_ff  <= 36'(numer[51:32]);
         nlow_ff <= numer[31:0];
         q_ff    <= '0;
         dvs_ff  <= absd;
         ovf_ff  <= 67'(numer) >= {absd, 32'h0000_0000};
         neg_ff  <= off[35] ^ dn_ff[34];
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? (r2 - {1'b0, dvs_ff}) : r2;
         nlow_ff <= {nlow_ff[30:0], 1'b0};
         q_ff    <= {q_ff[30:0], ge};
      end
      if (cmd.load_tn) begin
         tn_ff <= t_res;
      end
      if (cmd.p_load) begin
         case (cmd.pload_comp)
            2'd0:    px_ff <= psat;
            2'd1:    py_ff <= psat;
            default: pz_ff <= psat;
         endcase
      end
      if (cmd.cnt_clr) begin
         seen_ff <= 1'b0;
      end else if (cmd.chk) begin
         seen_ff <= seen_ff | inc;
      end
      if (cmd.res_basic) begin
         res_hit_ff  <= basic_hit;
         res_dist_ff <= basic_hit ? basic_dist : 32'sd0;
      end else if (cmd.res_edge) begin
         res_hit_ff  <= 1'b1;
         res_dist_ff <= t_sel;
      end else if (cmd.res_miss) begin
         res_hit_ff  <= 1'b0;
         res_dist_ff <= 32'sd0;
      end
      if (cmd.out_load) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_dist_ff <= res_dist_ff;
      end
   end

   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;

endmodule

`default_nettype wire

// File: design/svri_control.sv
`default_nettype none

module svri_control #(
   parameter int SLABS = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_opcode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire svri_pkg::status_type st,
   output svri_pkg::cmd_type         cmd
);

`include "slab_volume_ray_intersect_top_defines.svh"

   localparam logic [2:0] LAST = 3'(SLABS - 1);

   typedef enum logic [14:0] {
      ST_IDLE   = 15'h0001,
      ST_WIDEN  = 15'h0002,
      ST_DOTO   = 15'h0004,
      ST_DOTD   = 15'h0008,
      ST_DEN    = 15'h0010,
      ST_DSN    = 15'h0020,
      ST_DIVN   = 15'h0040,
      ST_DSF    = 15'h0080,
      ST_DIVF   = 15'h0100,
      ST_UPD    = 15'h0200,
      ST_DECIDE = 15'h0400,
      ST_PMUL   = 15'h0800,
      ST_EDOT   = 15'h1000,
      ST_ECHK   = 15'h2000,
      ST_DONE   = 15'h4000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] k_ff, k_in;
   logic       sel_ff, sel_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.sel_t = sel_ff;
      cmd.dot_src = svri_pkg::SRC_O;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.cap = 1'b1;
               case (req_opcode)
                  svri_pkg::OP_CLEAR: cmd.clear = 1'b1;
                  svri_pkg::OP_WIDEN: state_in = ST_WIDEN;
                  svri_pkg::OP_RAY: begin
                     idx_in   = '0;
                     state_in = ST_DOTO;
                  end
                  default: ;
               endcase
            end
         end
         ST_WIDEN: begin
            cmd.widen = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_DOTO: begin
            cmd.dot_go = 1'b1;
            state_in   = ST_DOTD;
         end
         ST_DOTD: begin
            cmd.load_on = 1'b1;
            cmd.dot_go  = 1'b1;
            cmd.dot_src = svri_pkg::SRC_D;
            state_in    = ST_DEN;
         end
         ST_DEN: begin
            cmd.load_dn = 1'b1;
            state_in    = ST_DSN;
         end
         ST_DSN: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = ST_DIVN;
         end
         ST_DIVN, ST_DIVF: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = (state_ff == ST_DIVN) ? ST_DSF : ST_UPD;
            end
         end
         ST_DSF: begin
            cmd.load_tn   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_far   = 1'b1;
            step_in       = '0;
            state_in      = ST_DIVF;
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_DOTO;
            end
         end
         ST_DECIDE: begin
            if (!st.edge_mode) begin
               cmd.res_basic = 1'b1;
               state_in      = ST_DONE;
            end else if (st.range_ok) begin
               cmd.cnt_clr = 1'b1;
               sel_in      = 1'b0;
               k_in        = '0;
               state_in    = ST_PMUL;
            end else begin
               cmd.res_miss = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_PMUL: begin
            // multiply one component while the previous one is saturated
            cmd.pmul_go    = (k_ff != 2'd3);
            cmd.pmul_comp  = k_ff;
            cmd.p_load     = (k_ff != 2'd0);
            cmd.pload_comp = k_ff - 2'd1;
            k_in           = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               idx_in   = '0;
               state_in = ST_EDOT;
            end
         end
         ST_EDOT: begin
            cmd.dot_go  = 1'b1;
            cmd.dot_src = svri_pkg::SRC_P;
            state_in    = ST_ECHK;
         end
         ST_ECHK: begin
            if (st.edge_now) begin
               cmd.res_edge = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.chk = 1'b1;
               if (idx_ff != LAST) begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_EDOT;
               end else if (!sel_ff) begin
                  sel_in      = 1'b1;
                  k_in        = '0;
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_PMUL;
               end else begin
                  cmd.res_miss = 1'b1;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         sel_ff   <= sel_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `SVRI_ASSERT_IMP(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `SVRI_ASSERT_NXT(a_ray_busy, accept && req_opcode == svri_pkg::OP_RAY, !req_ready, "ray not started")
   `SVRI_ASSERT_IMP(a_idx_range, cmd.dot_go || cmd.upd || cmd.chk, 32'(idx_ff) < SLABS, "slab index out of range")

endmodule

`default_nettype wire

// File: design/slab_volume_ray_intersect_top.sv
// Clear, widen and ray-test requests; a ray test ends in the result register,
// and wireframe mode adds point checks at tmin and, if needed, at tmax.
// Each slab runs two 32-step divisions through one shared bit-serial divider.
// One request at a time; a new request is taken while the last result waits.
// Synchronous active-high reset empties the volume and sets the edge width to 0.4.
`default_nettype none

module slab_volume_ray_intersect_top #(
   parameter int SLABS = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [1:0]         req_mode,
   input  wire logic [2:0]         req_slab,
   input  wire logic signed [31:0] req_near_value,
   input  wire logic signed [31:0] req_far_value,
   input  wire logic signed [31:0] req_origin_x,
   input  wire logic signed [31:0] req_origin_y,
   input  wire logic signed [31:0] req_origin_z,
   input  wire logic signed [31:0] req_dir_x,
   input  wire logic signed [31:0] req_dir_y,
   input  wire logic signed [31:0] req_dir_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_hit,
   output logic signed [31:0]      rsp_distance,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [30:0]        csr_edge_width
);

   svri_pkg::cmd_type    cmd;
   svri_pkg::status_type st;

   assign csr_ready = 1'b1;

   svri_control #(.SLABS(SLABS)) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .st         (st),
      .cmd        (cmd)
   );

   svri_datapath #(.SLABS(SLABS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_mode       (req_mode),
      .req_slab       (req_slab),
      .req_near_value (req_near_value),
      .req_far_value  (req_far_value),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_origin_z   (req_origin_z),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .csr_valid      (csr_valid),
      .csr_edge_width (csr_edge_width),
      .rsp_hit        (rsp_hit),
      .rsp_distance   (rsp_distance)
   );

endmodule

`default_nettype wire

// File: bench/tb_slab_volume_ray_intersect_top.sv
`default_nettype none

module tb_slab_volume_ray_intersect_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_SPARE   = 2'd3;
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int         NSLAB      = 7;
   localparam int         ONE        = 65536;
   localparam longint     QMAX_L     = 64'sd2147483647;
   localparam longint     QMIN_L     = -64'sd2147483648;

   typedef struct {
      logic [1:0]         opcode;
      logic [1:0]         mode;
      logic [2:0]         slab;
      logic signed [31:0] near_v;
      logic signed [31:0] far_v;
      logic signed [31:0] o [3];
      logic signed [31:0] d [3];
   } ray_req_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] distance;
   } hit_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [1:0]         req_mode;
   logic [2:0]         req_slab;
   logic signed [31:0] req_near_value;
   logic signed [31:0] req_far_value;
   logic signed [31:0] req_origin_x;
   logic signed [31:0] req_origin_y;
   logic signed [31:0] req_origin_z;
   logic signed [31:0] req_dir_x;
   logic signed [31:0] req_dir_y;
   logic signed [31:0] req_dir_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic signed [31:0] rsp_distance;
   logic               csr_valid;
   logic               csr_ready;
   logic [30:0]        csr_edge_width;

   // predictor state
   longint  near_b [NSLAB];
   longint  far_b  [NSLAB];
   longint  edge_w;
   hit_type hits_pending [$];

   int     fails;
   int     send_idle_pct;
   int     stall_pct;
   int     hold_left;

   slab_volume_ray_intersect_top #(.SLABS(NSLAB)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_mode      (req_mode),
      .req_slab      (req_slab),
      .req_near_value(req_near_value),
      .req_far_value (req_far_value),
      .req_origin_x  (req_origin_x),
      .req_origin_y  (req_origin_y),
      .req_origin_z  (req_origin_z),
      .req_dir_x     (req_dir_x),
      .req_dir_y     (req_dir_y),
      .req_dir_z     (req_dir_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_distance  (rsp_distance),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_edge_width(csr_edge_width)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic longint sat32(input longint v);
      if (v > QMAX_L) return QMAX_L;
      if (v < QMIN_L) return QMIN_L;
      return v;
   endfunction

   function automatic longint normal_dot(input int i, input longint x, input longint y,
                                         input longint z);
      longint s;
      case (i)
         0: return x;
         1: return y;
         2: return z;
         3: s = x + y + z;
         4: s = -x + y + z;
         5: s = -x - y + z;
         default: s = x - y + z;
      endcase
      return (s * 37837 + 32768) >>> 16;
   endfunction

   function automatic longint plane_t(input longint off, input longint den);
      if (den == 0) return (off >= 0) ? QMAX_L : QMIN_L;
      return sat32((off * ONE) / den);
   endfunction

   function automatic bit on_edge(input longint t, input longint o [3], input longint d [3]);
      longint p [3];
      longint dp, a, b;
      int count;
      count = 0;
      for (int k = 0; k < 3; k++) p[k] = sat32(o[k] + ((d[k] * t) >>> 16));
      for (int i = 0; i < NSLAB; i++) begin
         dp = normal_dot(i, p[0], p[1], p[2]);
         a = -near_b[i] - dp;
         b = -far_b[i] - dp;
         if (a < 0) a = -a;
         if (b < 0) b = -b;
         if (a < edge_w || b < edge_w) count++;
         if (count > 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic hit_type trace_ray(input ray_req_type r);
      hit_type h;
      longint  o [3];
      longint  d [3];
      longint  tmin, tmax, on, dn, tn, tf, x;
      tmin = QMIN_L;
      tmax = QMAX_L;
      h.hit = 1'b0;
      h.distance = '0;
      for (int k = 0; k < 3; k++) begin
         o[k] = r.o[k];
         d[k] = r.d[k];
      end
      for (int i = 0; i < NSLAB; i++) begin
         on = normal_dot(i, o[0], o[1], o[2]);
         dn = normal_dot(i, d[0], d[1], d[2]);
         tn = plane_t(-near_b[i] - on, dn);
         tf = plane_t(-far_b[i] - on, dn);
         if (tn > tf) begin
            x = tn;
            tn = tf;
            tf = x;
         end
         if (tn > tmin) tmin = tn;
         if (tf < tmax) tmax = tf;
      end
      if (r.mode == svri_pkg::MODE_NEAR) begin
         if (tmax > 0 && tmin <= tmax) begin
            h.hit = 1'b1;
            h.distance = 32'(tmin);
         end
      end else if (r.mode == svri_pkg::MODE_EDGE) begin
         if (tmax >= 0 && tmin <= tmax) begin
            if (on_edge(tmin, o, d)) begin
               h.hit = 1'b1;
               h.distance = 32'(tmin);
            end else if (on_edge(tmax, o, d)) begin
               h.hit = 1'b1;
               h.distance = 32'(tmax);
            end
         end
      end else if (tmax >= 0 && tmin <= tmax) begin
         h.hit = 1'b1;
         h.distance = 32'((tmin < 0) ? tmax : tmin);
      end
      return h;
   endfunction

   function automatic void empty_volume();
      for (int i = 0; i < NSLAB; i++) begin
         near_b[i] = QMAX_L;
         far_b[i] = QMIN_L;
      end
   endfunction

   function automatic void apply_request(input ray_req_type r);
      longint nv, fv;
      nv = r.near_v;
      fv = r.far_v;
      case (r.opcode)
         svri_pkg::OP_CLEAR: empty_volume();
         svri_pkg::OP_WIDEN: begin
            if (r.slab < NSLAB) begin
               if (nv < near_b[r.slab]) near_b[r.slab] = nv;
               if (fv > far_b[r.slab]) far_b[r.slab] = fv;
            end
         end
         svri_pkg::OP_RAY: hits_pending.push_back(trace_ray(r));
         default: ;
      endcase
   endfunction

   // ---------------- drivers ----------------

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_request(input ray_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_opcode     = r.opcode;
      req_mode       = r.mode;
      req_slab       = r.slab;
      req_near_value = r.near_v;
      req_far_value  = r.far_v;
      req_origin_x   = r.o[0];
      req_origin_y   = r.o[1];
      req_origin_z   = r.o[2];
      req_dir_x      = r.d[0];
      req_dir_y      = r.d[1];
      req_dir_z      = r.d[2];
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (hits_pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_edge_width(input logic [30:0] w);
      wait_drained();
      csr_edge_width = w;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      edge_w = w;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------- request builders ----------------

   function automatic logic signed [31:0] rnd_span(input int units);
      return $signed($urandom_range(0, 2 * units * 65536)) - units * 65536;
   endfunction

   function automatic ray_req_type blank_req(input logic [1:0] op);
      ray_req_type r;
      r.opcode = op;
      r.mode = MODE_FIRST;
      r.slab = '0;
      r.near_v = '0;
      r.far_v = '0;
      for (int k = 0; k < 3; k++) begin
         r.o[k] = '0;
         r.d[k] = '0;
      end
      return r;
   endfunction

   function automatic ray_req_type widen_req(input logic [2:0] s,
                                             input logic signed [31:0] nv,
                                             input logic signed [31:0] fv);
      ray_req_type r;
      r = blank_req(svri_pkg::OP_WIDEN);
      r.slab = s;
      r.near_v = nv;
      r.far_v = fv;
      return r;
   endfunction

   function automatic ray_req_type ray_req(input logic [1:0] m, input int ox, input int oy,
                                           input int oz, input int dx, input int dy,
                                           input int dz);
      ray_req_type r;
      r = blank_req(svri_pkg::OP_RAY);
      r.mode = m;
      r.o[0] = ox;
      r.o[1] = oy;
      r.o[2] = oz;
      r.d[0] = dx;
      r.d[1] = dy;
      r.d[2] = dz;
      return r;
   endfunction

   function automatic ray_req_type random_ray();
      ray_req_type r;
      r = blank_req(svri_pkg::OP_RAY);
      r.mode = 2'($urandom_range(0, 3));
      for (int k = 0; k < 3; k++) begin
         r.o[k] = rnd_span(20);
         r.d[k] = ($urandom_range(0, 7) == 0) ? 32'sd0 : rnd_span(2);
      end
      return r;
   endfunction

   function automatic ray_req_type noise_req();
      ray_req_type r;
      r.opcode = 2'($urandom_range(0, 3));
      r.mode = 2'($urandom_range(0, 3));
      r.slab = 3'($urandom_range(0, 7));
      r.near_v = $urandom;
      r.far_v = $urandom;
      for (int k = 0; k < 3; k++) begin
         r.o[k] = $urandom;
         r.d[k] = $urandom;
      end
      return r;
   endfunction

   task automatic build_volume();
      logic signed [31:0] lo, hi;
      send_request(blank_req(svri_pkg::OP_CLEAR));
      for (int s = 0; s < NSLAB; s++) begin
         lo = rnd_span(10);
         hi = lo + $signed($urandom_range(0, 12 * 65536));
         send_request(widen_req(3'(s), -hi, -lo));
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      send_request(ray_req(MODE_FIRST, 0, 0, 0, ONE, 0, 0));
      send_request(ray_req(svri_pkg::MODE_NEAR, 0, 0, 0, 0, 0, 0));
      send_request(ray_req(svri_pkg::MODE_EDGE, 0, 0, 0, ONE, ONE, ONE));
      // unit box [-1,1]^3 with diagonals loose around it
      for (int s = 0; s < 3; s++) send_request(widen_req(3'(s), -ONE, ONE));
      for (int s = 3; s < NSLAB; s++)
         send_request(widen_req(3'(s), -2 * ONE, 2 * ONE));
      send_request(widen_req(3'd7, 32'sh8000_0000, 32'sh7fff_ffff));
      send_request(blank_req(OP_SPARE));
      send_request(ray_req(MODE_FIRST, -5 * ONE, 0, 0, ONE, 0, 0));
      send_request(ray_req(svri_pkg::MODE_NEAR, -5 * ONE, 0, 0, ONE, 0, 0));
      send_request(ray_req(svri_pkg::MODE_EDGE, -5 * ONE, ONE, ONE, ONE, 0, 0));
      send_request(ray_req(MODE_SPARE, 0, 0, 0, 0, ONE, 0));
      // origin on a face: hit at distance zero
      send_request(ray_req(MODE_FIRST, -ONE, 0, 0, ONE, 0, 0));
      send_request(ray_req(svri_pkg::MODE_NEAR, 0, 0, 0, 0, 0, 0));
      send_request(ray_req(MODE_FIRST, 5 * ONE, 0, 0, ONE, 0, 0));
      send_request(ray_req(MODE_FIRST, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
      send_request(widen_req(3'd0, 32'sh8000_0000, 32'sh7fff_ffff));
      send_request(ray_req(svri_pkg::MODE_EDGE, 0, 0, 0, 32'sh7fff_ffff, 0, -1));
      send_request(blank_req(svri_pkg::OP_CLEAR));
      send_request(ray_req(MODE_FIRST, 0, 0, 0, ONE, 0, 0));
      wait_drained();
   endtask

   task automatic test_random(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            build_volume();
            sent += NSLAB + 1;
         end else if (pick < 14) begin
            send_request(widen_req(3'($urandom_range(0, 7)), rnd_span(12), rnd_span(12)));
            sent++;
         end else if (pick < 22) begin
            send_request(noise_req());
            sent++;
         end else begin
            send_request(random_ray());
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      send_idle_pct = 0;
      stall_pct = 0;
      build_volume();
      hold_left = 3000;
      for (int i = 0; i < 6; i++) send_request(random_ray());
      // sender waits for everything before going on
      wait_drained();
   endtask

   task automatic test_phases();
      write_edge_width(31'h7fff_ffff);
      send_idle_pct = 0;
      stall_pct = 0;
      test_random(500);
      write_edge_width(31'd0);
      send_idle_pct = 75;
      stall_pct = 0;
      test_random(500);
      write_edge_width(31'($urandom_range(0, 3 * 65536)));
      send_idle_pct = 0;
      stall_pct = 75;
      test_random(500);
      write_edge_width(31'($urandom));
      send_idle_pct = 31;
      stall_pct = 31;
      test_random(250);
      write_edge_width(svri_pkg::EDGE_RESET);
      test_random(250);
   endtask

   // ---------------- result check ----------------

   always @(posedge clock) begin
      hit_type h;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hits_pending.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result hit=%0d distance=%0d",
                                      rsp_hit, rsp_distance);
         end else begin
            h = hits_pending.pop_front();
            if (rsp_hit !== h.hit || rsp_distance !== h.distance) begin
               fails++;
               if (fails <= 10)
                  $display("mismatch: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                           h.hit, h.distance, rsp_hit, rsp_distance);
            end
         end
      end
   end

   initial begin
      fails = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = svri_pkg::OP_CLEAR;
      req_mode = MODE_FIRST;
      req_slab = '0;
      req_near_value = '0;
      req_far_value = '0;
      req_origin_x = '0;
      req_origin_y = '0;
      req_origin_z = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_edge_width = '0;
      empty_volume();
      edge_w = svri_pkg::EDGE_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_phases();
      wait_drained();
      repeat (600) @(negedge clock);
      if (fails == 0 && hits_pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
